/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must be parenthesized when it holds a comma
`define AST_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AST_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* src/urxrb_pkg.sv */
package urxrb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int PERIOD_W  = 24;
    localparam int CNT_W     = 25;
    localparam int BYTE_W    = 8;
    localparam int BIT_W     = 4;
    localparam int FILL_W    = 6;

    // bit count after the last data bit, and after the stop bit
    localparam logic [BIT_W-1:0] DATA_BITS  = 4'd8;
    localparam logic [BIT_W-1:0] FRAME_BITS = 4'd9;

    typedef enum logic {
        RX_IDLE,
        RX_FRAME
    } t_rx_state;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_rx_push;

endpackage

/* src/uart_rx_with_ring_buffer_top.sv */
// UART 8N1 receiver with ring buffer, one line sample per item.
// Throughput: one item per cycle unless o_in_stall (output held and stalled);
// the store is read ahead every cycle at the next front slot. The result sits
// in the output register from the cycle after acceptance.
// Reset (sync, active low): receiver idle, buffer empty, period 0 (receiver
// off); the byte store is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module uart_rx_with_ring_buffer_top #(
    parameter int DEPTH = urxrb_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_line_level,
    input  logic                                i_pop_request,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [urxrb_pkg::BYTE_W-1:0]        o_front_byte,
    output logic                                o_front_valid,
    output logic [urxrb_pkg::FILL_W-1:0]        o_fill_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [urxrb_pkg::PERIOD_W-1:0]      i_cfg_data
);
    import urxrb_pkg::*;

    logic [PERIOD_W-1:0]  r_period;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_front_byte;
    logic                 r_front_valid;
    logic [FILL_W-1:0]    r_fill_count;

    logic                 en;
    t_rx_push             push;
    logic [BYTE_W-1:0]    front_byte;
    logic                 front_valid;
    logic [FILL_W-1:0]    fill_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign en          = i_in_valid && !o_in_stall;

    urxrb_rx u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_level  (i_line_level),
        .i_period (r_period),
        .o_push   (push)
    );

    urxrb_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_pop         (i_pop_request),
        .i_push        (push),
        .o_front_byte  (front_byte),
        .o_front_valid (front_valid),
        .o_fill_count  (fill_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_period <= i_cfg_data;
            if (en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_front_byte  <= front_byte;
            r_front_valid <= front_valid;
            r_fill_count  <= fill_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_byte  = r_front_byte;
    assign o_front_valid = r_front_valid;
    assign o_fill_count  = r_fill_count;

    `AST_HOLDS(a_accept_out, i_clk, i_rst_n, (en |=> o_out_valid), "accepted item without result")
    `AST_HOLDS(a_empty_go, i_clk, i_rst_n, (!r_out_valid |-> !o_in_stall), "empty output stalls input")
    `AST_HOLDS(a_cfg_write, i_clk, i_rst_n, ((i_cfg_valid && o_cfg_ready) |=> (r_period == $past(i_cfg_data))), "period not written")

endmodule

/* src/urxrb_rx.sv */
`include "assert_macros.svh"

module urxrb_rx (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_level,
    input  logic [urxrb_pkg::PERIOD_W-1:0]      i_period,
    output urxrb_pkg::t_rx_push                 o_push
);
    import urxrb_pkg::*;

    t_rx_state          r_state, n_state;
    logic               r_last, n_last;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BIT_W-1:0]   r_bits, n_bits;
    logic [BYTE_W-1:0]  r_shift, n_shift;

    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   start_cnt;
    logic [BIT_W-1:0]   bits_inc;
    logic               start_edge;

    assign cnt_dec    = (r_cnt != '0) ? (r_cnt - 1'b1) : '0;
    assign bits_inc   = r_bits + 1'b1;
    assign start_cnt  = CNT_W'(i_period) + CNT_W'(i_period >> 1);
    assign start_edge = r_last && !i_level;

    always_comb begin
        n_state = r_state;
        if (i_en) begin
            if (i_period == '0) begin
                n_state = RX_IDLE;
            end else begin
                unique case (r_state)
                    RX_IDLE: begin
                        if (start_edge) n_state = RX_FRAME;
                    end
                    RX_FRAME: begin
                        if (cnt_dec == '0 && bits_inc >= FRAME_BITS) n_state = RX_IDLE;
                    end
                    default: n_state = RX_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_last  = i_en ? i_level : r_last;
        o_push  = '0;
        if (i_en && i_period != '0) begin
            case (r_state)
                RX_IDLE: begin
                    if (start_edge) begin
                        n_cnt   = start_cnt;
                        n_bits  = '0;
                        n_shift = '0;
                    end
                end
                RX_FRAME: begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        if (r_bits < DATA_BITS && i_level) begin
                            n_shift = r_shift | (BYTE_W'(1) << r_bits[2:0]);
                        end
                        n_bits = bits_inc;
                        if (bits_inc == DATA_BITS) begin
                            o_push.valid = 1'b1;
                            o_push.data  = n_shift;
                        end
                        if (bits_inc < FRAME_BITS) n_cnt = CNT_W'(i_period);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_IDLE;
            r_last  <= 1'b1;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_shift <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_shift <= n_shift;
        end
    end

    `AST_HOLDS(a_start, i_clk, i_rst_n, ((i_en && r_state == RX_IDLE && i_period != '0 && start_edge) |=> (r_state == RX_FRAME && r_bits == '0)), "frame start not taken")
    `AST_HOLDS(a_push_bits, i_clk, i_rst_n, (o_push.valid |=> (r_bits == DATA_BITS)), "push without eight bits")
    `AST_HOLDS(a_disable, i_clk, i_rst_n, ((i_en && i_period == '0) |=> (r_state == RX_IDLE)), "receiver not stopped")

endmodule

/* src/urxrb_fifo.sv */
`include "assert_macros.svh"

module urxrb_fifo #(
    parameter int DEPTH = urxrb_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_pop,
    input  urxrb_pkg::t_rx_push                 i_push,
    output logic [urxrb_pkg::BYTE_W-1:0]        o_front_byte,
    output logic                                o_front_valid,
    output logic [urxrb_pkg::FILL_W-1:0]        o_fill_count
);
    import urxrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;

    logic [BYTE_W-1:0]  mem [DEPTH];
    logic [BYTE_W-1:0]  r_q;
    logic               r_byp;
    logic [BYTE_W-1:0]  r_byp_data;
    logic [AW-1:0]      r_wr, n_wr;
    logic [AW-1:0]      r_rd, n_rd;
    logic [AW-1:0]      wr_next;
    logic [AW-1:0]      rd_next;
    logic [FW-1:0]      fill;
    logic               do_pop;
    logic               do_wr;

    assign wr_next = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign fill    = (r_wr >= r_rd) ? (FW'(r_wr) - FW'(r_rd))
                                    : (FW'(DEPTH) + FW'(r_wr) - FW'(r_rd));

    assign o_front_valid = (fill != '0);
    assign o_fill_count  = fill[FILL_W-1:0];
    assign o_front_byte  = !o_front_valid ? '0 : (r_byp ? r_byp_data : r_q);

    assign do_pop = i_en && i_pop && o_front_valid;
    assign n_rd   = do_pop ? rd_next : r_rd;
    assign do_wr  = i_push.valid && (wr_next != n_rd);
    assign n_wr   = do_wr ? wr_next : r_wr;

    // read-first store; a write to the slot read next is forwarded
    always_ff @(posedge i_clk) begin
        if (do_wr) mem[r_wr] <= i_push.data;
        r_q        <= mem[n_rd];
        r_byp_data <= i_push.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_byp <= 1'b0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_byp <= do_wr && (r_wr == n_rd);
        end
    end

    `AST_HOLDS(a_fill_up, i_clk, i_rst_n, ((do_wr && !do_pop) |=> (fill == $past(fill) + 1'b1)), "fill did not grow")
    `AST_HOLDS(a_fill_dn, i_clk, i_rst_n, ((do_pop && !do_wr) |=> (fill == $past(fill) - 1'b1)), "fill did not shrink")
    `AST_NEVER(a_overfill, i_clk, i_rst_n, (fill >= FW'(DEPTH)), "fill beyond capacity")

endmodule
